/* hw/rtl/weighted_server_task_dispatcher_assert.svh */
// Assertion helpers for the task dispatcher.
// Each check is clocked on clk and held off while arst_n is low.
`ifndef WEIGHTED_SERVER_TASK_DISPATCHER_ASSERT_SVH
`define WEIGHTED_SERVER_TASK_DISPATCHER_ASSERT_SVH

// Same-cycle implication
`define WSTD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define WSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/wstd_pkg.sv */
package wstd_pkg;

	// Server pool size and derived widths
	localparam int unsigned SERVERS = 16;
	localparam int unsigned SRV_W   = $clog2(SERVERS);
	localparam int unsigned CNT_W   = SRV_W + 1;

	// Fixed field widths
	localparam int unsigned CFG_W  = 5;
	localparam int unsigned SEL_W  = 4;
	localparam int unsigned WGT_W  = 16;
	localparam int unsigned DUR_W  = 16;
	localparam int unsigned TIME_W = 32;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// Command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SUBMIT = 1'b1;

	typedef struct packed {
		logic             command;
		logic [SEL_W-1:0] server_select;
		logic [WGT_W-1:0] weight;
		logic [DUR_W-1:0] duration;
	} in_t;

	typedef struct packed {
		logic [SEL_W-1:0]  assigned_server;
		logic [TIME_W-1:0] start_time;
		logic              time_overflow;
	} out_t;

endpackage

/* hw/rtl/weighted_server_task_dispatcher.sv */
// Channel | Direction | Handshake            | Beat contents
// config  | in        | cfg_wr_en            | cfg_wr_data: server_count
// task in | in        | in_valid / in_ready  | in_data: command, select, weight, duration
// result  | out       | out_valid / out_ready| out_data: server, start time, overflow flag
//
// A load beat is taken while idle and gives no result.
// A submit beat is latched, then walked over the N active servers (N the active count):
// one shared compare path walks the servers one per cycle, then the update state writes.
// in_ready is low during the walk; the update waits while an earlier result is unread.
// Reset clears all busy times, the clock, the task counter and sets 16 servers.

`include "weighted_server_task_dispatcher_assert.svh"

module weighted_server_task_dispatcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [wstd_pkg::CFG_W-1:0]      cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  wstd_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output wstd_pkg::out_t                  out_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t                              state_q;
	logic [wstd_pkg::CFG_W-1:0]          cnt_q;
	logic [wstd_pkg::WGT_W-1:0]          weight_q [wstd_pkg::SERVERS];
	logic [wstd_pkg::TIME_W-1:0]         busy_q   [wstd_pkg::SERVERS];
	logic [wstd_pkg::TIME_W-1:0]         cur_time_q;
	logic [wstd_pkg::TIME_W-1:0]         task_cnt_q;
	logic [wstd_pkg::TIME_W-1:0]         start_q;
	logic [wstd_pkg::DUR_W-1:0]          dur_q;
	logic [wstd_pkg::CNT_W-1:0]          n_q;
	logic [wstd_pkg::SRV_W-1:0]          idx_q;
	logic                                a_found_q;
	logic [wstd_pkg::SRV_W-1:0]          a_idx_q;
	logic [wstd_pkg::WGT_W-1:0]          a_wgt_q;
	logic [wstd_pkg::SRV_W-1:0]          b_idx_q;
	logic [wstd_pkg::WGT_W-1:0]          b_wgt_q;
	logic [wstd_pkg::TIME_W-1:0]         b_min_q;
	logic                                out_valid_q;
	wstd_pkg::out_t                      out_q;

	logic                                in_fire;
	logic                                upd_fire;
	logic                                scan_last;
	logic [wstd_pkg::CNT_W-1:0]          act_cnt;
	logic [wstd_pkg::TIME_W-1:0]         arr_start;
	logic [wstd_pkg::TIME_W-1:0]         rd_busy;
	logic [wstd_pkg::WGT_W-1:0]          rd_wgt;
	logic                                rd_free;
	logic                                a_take;
	logic                                b_new_min;
	logic                                b_tie;
	logic [wstd_pkg::TIME_W-1:0]         sel_time;
	logic [wstd_pkg::SRV_W-1:0]          sel_idx;
	logic [wstd_pkg::TIME_W:0]           finish;
	logic                                ovf;
	logic [wstd_pkg::TIME_W-1:0]         fin_sat;

	// Handshake
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign upd_fire  = (state_q == ST_UPD) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Clamp the active count to 1 .. SERVERS
	always_comb begin
		if (cnt_q == '0) begin
			act_cnt = wstd_pkg::CNT_W'(1);
		end else if (cnt_q > wstd_pkg::CFG_W'(wstd_pkg::SERVERS)) begin
			act_cnt = wstd_pkg::CNT_W'(wstd_pkg::SERVERS);
		end else begin
			act_cnt = wstd_pkg::CNT_W'(cnt_q);
		end
	end

	// Start is the later of arrival and the previous start
	assign arr_start = (cur_time_q < task_cnt_q) ? task_cnt_q : cur_time_q;

	// Shared compare path for the server walk
	assign rd_busy   = busy_q[idx_q];
	assign rd_wgt    = weight_q[idx_q];
	assign rd_free   = (rd_busy <= start_q);
	assign a_take    = rd_free && (!a_found_q || (rd_wgt < a_wgt_q));
	assign b_new_min = (idx_q == '0) || (rd_busy < b_min_q);
	assign b_tie     = (rd_busy == b_min_q) && (rd_wgt < b_wgt_q);
	assign scan_last = ({1'b0, idx_q} == (n_q - wstd_pkg::CNT_W'(1)));

	// Pick free-at-start winner, else the earliest-free winner
	assign sel_time = a_found_q ? start_q : b_min_q;
	assign sel_idx  = a_found_q ? a_idx_q : b_idx_q;
	assign finish   = {1'b0, sel_time} + (wstd_pkg::TIME_W + 1)'(dur_q);
	assign ovf      = finish[wstd_pkg::TIME_W];
	assign fin_sat  = ovf ? wstd_pkg::TIME_MAX : finish[wstd_pkg::TIME_W-1:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (in_data.command == wstd_pkg::CMD_SUBMIT)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (upd_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= wstd_pkg::CFG_W'(wstd_pkg::SERVERS);
		end else if (cfg_wr_en) begin
			cnt_q <= cfg_wr_data;
		end
	end

	// Weight store: undefined until loaded
	always_ff @(posedge clk) begin
		if (in_fire && (in_data.command == wstd_pkg::CMD_LOAD)
				&& (32'(in_data.server_select) < wstd_pkg::SERVERS)) begin
			weight_q[in_data.server_select[wstd_pkg::SRV_W-1:0]] <= in_data.weight;
		end
	end

	// Busy times, clock and task counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wstd_pkg::SERVERS; i++) begin
				busy_q[wstd_pkg::SRV_W'(i)] <= '0;
			end
			cur_time_q <= '0;
			task_cnt_q <= '0;
		end else if (upd_fire) begin
			busy_q[sel_idx] <= fin_sat;
			cur_time_q      <= sel_time;
			if (task_cnt_q != wstd_pkg::TIME_MAX) begin
				task_cnt_q <= task_cnt_q + wstd_pkg::TIME_W'(1);
			end
		end
	end

	// Task latch and walk candidates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			a_found_q <= 1'b0;
		end else if (in_fire) begin
			idx_q     <= '0;
			a_found_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (a_take) begin
				a_found_q <= 1'b1;
			end
			if (!scan_last) begin
				idx_q <= idx_q + wstd_pkg::SRV_W'(1);
			end
		end
	end

	// Payload of the walk: no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			start_q <= arr_start;
			dur_q   <= in_data.duration;
			n_q     <= act_cnt;
		end else if (state_q == ST_SCAN) begin
			if (a_take) begin
				a_idx_q <= idx_q;
				a_wgt_q <= rd_wgt;
			end
			if (b_new_min || b_tie) begin
				b_idx_q <= idx_q;
				b_wgt_q <= rd_wgt;
				b_min_q <= rd_busy;
			end
		end
	end

	// Result register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			out_q.assigned_server <= wstd_pkg::SEL_W'(sel_idx);
			out_q.start_time      <= sel_time;
			out_q.time_overflow   <= ovf;
		end
	end

	// Checks
	`WSTD_ASSERT_NEXT(a_upd_gives_result, upd_fire, out_valid_q, "update gave no result")
	`WSTD_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, ({1'b0, idx_q} < n_q), "walk past active count")
	`WSTD_ASSERT_NEXT(a_upd_sets_busy, upd_fire, busy_q[$past(sel_idx)] == $past(fin_sat), "busy time not written")
	`WSTD_ASSERT_IMP(a_upd_time_order, upd_fire, sel_time >= cur_time_q, "start time went backwards")

endmodule
